// ===== rtl/qvd_pkg.sv =====
package qvd_pkg;

  localparam int unsigned CmdW        = 2;
  localparam int unsigned DimIndexW   = 10;
  localparam int unsigned QueryW      = 24;
  localparam int unsigned MultW       = 24;
  localparam int unsigned CodeW       = 8;
  localparam int unsigned DistW       = 64;
  localparam int unsigned VecNumW     = 12;
  localparam int unsigned ModeW       = 1;
  localparam int unsigned DimsW       = 11;
  localparam int unsigned ProdW       = 32;

  // register indexes on the configuration port
  localparam logic REG_METRIC_MODE = 1'b0;
  localparam logic REG_DIMS_IN_USE = 1'b1;

  localparam logic MODE_DOT = 1'b0;
  localparam logic MODE_L2  = 1'b1;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD = 2'd0,
    CMD_CODE = 2'd1,
    CMD_SKIP = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQR,
    ST_ACC,
    ST_EMIT,
    ST_SKIP
  } state_t;

  typedef struct packed {
    logic mem_wr;
    logic start;
    logic mul_en;
    logic sqr_en;
    logic acc_en;
    logic emit_vec;
    logic emit_skip;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/quantized_vector_distance.sv =====
// channel  | direction | contents
// s_*      | in        | tuser: command; tdata: dim_index, query_value, inverse_multiplier, code
// m_*      | out       | tuser: skipped; tdata: distance, vector_number
// apb      | in/out    | metric_mode at 0x0, dims_in_use at 0x4
//
// a load request writes the stores in idle; a code request passes through the
// single read port of the stores, the multiply and square stages and the accumulator
// the closing code of a vector hands the score to the output register from the emit state
// a skip passes the skip state; results wait in the output register while m_tready is low
// reset is synchronous and clears control and the sum; the stores hold whatever was loaded
module quantized_vector_distance #(
  parameter int unsigned MAX_DIMS           = 1024,
  parameter int unsigned VECTOR_COUNT_LIMIT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // dim_index, query_value, inverse_multiplier, code_value
  input  logic [1:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // distance, vector_number
  output logic        m_tuser,   // skipped
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import qvd_pkg::*;

  logic                     metric_mode;
  logic [DimsW-1:0]         dims_in_use;
  logic                     reg_wr;
  dp_cmd_t                  cmd;
  dp_stat_t                 stat;
  logic signed [DistW-1:0]  distance;
  logic [VecNumW-1:0]       vector_number;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      metric_mode <= MODE_DOT;
      dims_in_use <= DimsW'(1024);
    end else if (reg_wr) begin
      case (paddr[2])
        REG_METRIC_MODE: metric_mode <= pwdata[0];
        REG_DIMS_IN_USE: dims_in_use <= pwdata[DimsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_METRIC_MODE: prdata = {31'b0, metric_mode};
      REG_DIMS_IN_USE: prdata = {{(32-DimsW){1'b0}}, dims_in_use};
      default:         prdata = '0;
    endcase
  end

  qvd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .command  (cmd_t'(s_tuser)),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  qvd_datapath #(
    .MAX_DIMS           (MAX_DIMS),
    .VECTOR_COUNT_LIMIT (VECTOR_COUNT_LIMIT)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .metric_mode        (metric_mode),
    .dims_in_use        (dims_in_use),
    .dim_index          (s_tdata[9:0]),
    .query_value        (s_tdata[33:10]),
    .inverse_multiplier (s_tdata[57:34]),
    .code_value         (s_tdata[65:58]),
    .m_tready           (m_tready),
    .m_tvalid           (m_tvalid),
    .distance           (distance),
    .skipped            (m_tuser),
    .vector_number      (vector_number)
  );

  assign m_tdata = {4'b0, vector_number, distance};

endmodule

// ===== rtl/qvd_ctrl.sv =====
module qvd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  qvd_pkg::cmd_t     command,
  output logic              s_tready,
  input  qvd_pkg::dp_stat_t stat,
  output qvd_pkg::dp_cmd_t  cmd
);
  import qvd_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (command)
            CMD_LOAD: cmd.mem_wr = 1'b1;
            CMD_CODE: begin
              cmd.start  = 1'b1;
              state_next = ST_MUL;
            end
            CMD_SKIP: state_next = ST_SKIP;
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = ST_SQR;
      end
      ST_SQR: begin
        cmd.sqr_en = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_en = 1'b1;
        state_next = stat.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_vec = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_SKIP: begin
        if (stat.out_free) begin
          cmd.emit_skip = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_emit_wait: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_EMIT || state == ST_SKIP) && !stat.out_free) |=> $stable(state))
    else $error("result left its state while the output register was full");

endmodule

// ===== rtl/qvd_datapath.sv =====
module qvd_datapath #(
  parameter int unsigned MAX_DIMS           = 1024,
  parameter int unsigned VECTOR_COUNT_LIMIT = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  qvd_pkg::dp_cmd_t                  cmd,
  output qvd_pkg::dp_stat_t                 stat,
  input  logic                              metric_mode,
  input  logic [qvd_pkg::DimsW-1:0]         dims_in_use,
  input  logic [qvd_pkg::DimIndexW-1:0]     dim_index,
  input  logic signed [qvd_pkg::QueryW-1:0] query_value,
  input  logic signed [qvd_pkg::MultW-1:0]  inverse_multiplier,
  input  logic signed [qvd_pkg::CodeW-1:0]  code_value,
  input  logic                              m_tready,
  output logic                              m_tvalid,
  output logic signed [qvd_pkg::DistW-1:0]  distance,
  output logic                              skipped,
  output logic [qvd_pkg::VecNumW-1:0]       vector_number
);
  import qvd_pkg::*;

  localparam int unsigned AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned CW = $clog2(MAX_DIMS + 1);
  localparam int unsigned VW = $clog2(VECTOR_COUNT_LIMIT);

  logic signed [QueryW-1:0] query_store [MAX_DIMS];
  logic signed [MultW-1:0]  multiplier_store [MAX_DIMS];

  logic signed [QueryW-1:0] q_rd;
  logic signed [MultW-1:0]  m_rd;
  logic signed [CodeW-1:0]  code_reg;
  logic [CW-1:0]            pos_reg;
  logic signed [ProdW-1:0]  qc_prod;
  logic signed [ProdW-1:0]  cm_prod;
  logic signed [DistW-1:0]  term;
  logic signed [DistW-1:0]  running_sum;
  logic [CW-1:0]            element_count;
  logic [VW-1:0]            vector_count;

  logic [CW-1:0]            dims_eff;
  logic [CW-1:0]            pos;
  logic [CW-1:0]            pos_inc;
  logic [31:0]              idx32;
  logic                     idx_ok;
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            rd_addr;
  logic signed [ProdW-1:0]  diff;
  logic [ProdW-2:0]         diff_mag;
  logic signed [DistW-1:0]  dot_term;
  logic signed [DistW:0]    sum_wide;
  logic signed [DistW-1:0]  sum_sat;
  logic signed [DistW-1:0]  dist_final;
  logic [31:0]              vc32;

  // effective dimension count: zero acts as one, clipped to the store depth
  always_comb begin
    if (dims_in_use == '0) begin
      dims_eff = CW'(1);
    end else if (32'(dims_in_use) > MAX_DIMS) begin
      dims_eff = CW'(MAX_DIMS);
    end else begin
      dims_eff = CW'(dims_in_use);
    end
  end

  assign pos     = (element_count >= dims_eff) ? dims_eff - CW'(1) : element_count;
  assign pos_inc = pos_reg + CW'(1);
  assign idx32   = 32'(dim_index);
  assign idx_ok  = idx32 < MAX_DIMS;
  assign wr_addr = idx32[AW-1:0];
  assign rd_addr = pos[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && idx_ok) begin
      query_store[wr_addr]      <= query_value;
      multiplier_store[wr_addr] <= inverse_multiplier;
    end
    if (cmd.start) begin
      q_rd <= query_store[rd_addr];
      m_rd <= multiplier_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      code_reg <= code_value;
      pos_reg  <= pos;
    end
    if (cmd.mul_en) begin
      qc_prod <= ProdW'(q_rd) * ProdW'(code_reg);
      cm_prod <= ProdW'(code_reg) * ProdW'(m_rd);
    end
    if (cmd.sqr_en) begin
      term <= (metric_mode == MODE_L2) ? $signed(DistW'(diff_mag) * DistW'(diff_mag))
                                       : dot_term;
    end
  end

  // |q - c*m| stays below 2^31, so the magnitude fits 31 bits
  assign diff     = ProdW'(q_rd) - cm_prod;
  assign diff_mag = diff[ProdW-1] ? (ProdW-1)'(-diff) : diff[ProdW-2:0];
  assign dot_term = DistW'(qc_prod) <<< 16;

  assign sum_wide = {running_sum[DistW-1], running_sum} + {term[DistW-1], term};

  always_comb begin
    if (sum_wide[DistW] != sum_wide[DistW-1]) begin
      sum_sat = sum_wide[DistW] ? {1'b1, {(DistW-1){1'b0}}} : {1'b0, {(DistW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[DistW-1:0];
    end
  end

  always_comb begin
    if (metric_mode == MODE_L2) begin
      dist_final = running_sum;
    end else if (running_sum == {1'b1, {(DistW-1){1'b0}}}) begin
      dist_final = {1'b0, {(DistW-1){1'b1}}};
    end else begin
      dist_final = -running_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      element_count <= '0;
      vector_count  <= '0;
    end else if (cmd.emit_vec || cmd.emit_skip) begin
      running_sum   <= '0;
      element_count <= '0;
      vector_count  <= (vector_count == VW'(VECTOR_COUNT_LIMIT - 1)) ? '0
                                                                     : vector_count + VW'(1);
    end else if (cmd.acc_en) begin
      running_sum   <= sum_sat;
      element_count <= pos_inc;
    end
  end

  assign vc32 = 32'(vector_count);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_vec || cmd.emit_skip) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_vec || cmd.emit_skip) begin
      distance      <= cmd.emit_skip ? '0 : dist_final;
      skipped       <= cmd.emit_skip;
      vector_number <= vc32[VecNumW-1:0];
    end
  end

  assign stat.out_free = !m_tvalid || m_tready;
  assign stat.last     = pos_inc >= dims_eff;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(element_count) <= MAX_DIMS)
    else $error("element count beyond store depth");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_vec || cmd.emit_skip) |=> (running_sum == '0 && element_count == '0))
    else $error("sum or count not cleared after a result");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_vec || cmd.emit_skip) |=> m_tvalid)
    else $error("result not presented after emit");

endmodule

// ===== verif/tb_quantized_vector_distance.sv =====
module tb_quantized_vector_distance;
  import qvd_pkg::*;

  localparam int unsigned MAX_DIMS      = 1024;
  localparam int          PHASES        = 16;
  localparam int          PHASE_ITEMS   = 97;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          QUIET_LIMIT   = 4000;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic signed [23:0] Q_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] Q_MIN = 24'sh800000;
  localparam logic signed [7:0]  C_MAX = 8'sh7F;
  localparam logic signed [7:0]  C_MIN = 8'sh80;
  localparam longint             D_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint             D_MIN = 64'sh8000_0000_0000_0000;
  // plus and minus 2^46
  localparam longint             P2_46 = 64'sh0000_4000_0000_0000;
  localparam longint             N2_46 = 64'shFFFF_C000_0000_0000;

  typedef struct packed {
    logic signed [63:0] distance;
    logic               skipped;
    logic [11:0]        vector_number;
  } score_t;

  typedef struct packed {
    logic               is_reg;
    logic               reg_sel;
    logic [31:0]        reg_value;
    logic [1:0]         cmd;
    logic [9:0]         idx;
    logic signed [23:0] qv;
    logic signed [23:0] mv;
    logic signed [7:0]  code;
    logic               known;
    score_t             known_score;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;  // dim_index, query_value, inverse_multiplier, code_value
  logic [1:0]  s_tuser = '0;  // command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;       // distance, vector_number
  logic        m_tuser;       // skipped
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  quantized_vector_distance dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // scoring model state
  logic signed [23:0] query_mem [MAX_DIMS];
  logic signed [23:0] mult_mem [MAX_DIMS];
  bit                 loaded [MAX_DIMS];
  longint             acc_sum = 0;
  int unsigned        elem_count = 0;
  logic [11:0]        vec_count = '0;
  logic               mode_reg = MODE_DOT;
  logic [10:0]        dims_reg = 11'd1024;

  score_t   pending_scores [$];
  dir_row_t directed_rows [$];

  int errors = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int quiet = 0;
  int requests_sent = 0;
  int settings_used = 0;
  int scores_checked = 0;
  int skips_checked = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned effective_dims();
    if (dims_reg == 0) return 1;
    if (dims_reg > MAX_DIMS) return MAX_DIMS;
    return 32'(dims_reg);
  endfunction

  function automatic int unsigned next_position();
    int unsigned dims;
    dims = effective_dims();
    return (elem_count >= dims) ? dims - 1 : elem_count;
  endfunction

  function automatic bit predict_score(input logic [1:0] cmd, input logic [9:0] idx,
                                       input logic signed [23:0] qv,
                                       input logic signed [23:0] mv,
                                       input logic signed [7:0] code, output score_t res);
    int unsigned pos;
    longint qx, mx, cx, diff, term, d;
    res = '0;
    if (cmd == CMD_LOAD) begin
      query_mem[idx] = qv;
      mult_mem[idx] = mv;
      loaded[idx] = 1'b1;
      return 1'b0;
    end
    if (cmd == CMD_SKIP) begin
      res.skipped = 1'b1;
      res.vector_number = vec_count;
      vec_count++;
      acc_sum = 0;
      elem_count = 0;
      return 1'b1;
    end
    if (cmd != CMD_CODE) return 1'b0;
    pos = next_position();
    qx = query_mem[pos];
    cx = code;
    if (mode_reg == MODE_DOT) begin
      term = qx * cx * 65536;
    end else begin
      mx = mult_mem[pos];
      diff = qx - cx * mx;
      term = diff * diff;
    end
    if (term > 0 && acc_sum > D_MAX - term) acc_sum = D_MAX;
    else if (term < 0 && acc_sum < D_MIN - term) acc_sum = D_MIN;
    else acc_sum = acc_sum + term;
    elem_count = pos + 1;
    if (elem_count < effective_dims()) return 1'b0;
    d = acc_sum;
    if (mode_reg == MODE_DOT) d = (d == D_MIN) ? D_MAX : -d;
    res.distance = d;
    res.vector_number = vec_count;
    vec_count++;
    acc_sum = 0;
    elem_count = 0;
    return 1'b1;
  endfunction

  function automatic dir_row_t req(input logic [1:0] cmd, input logic [9:0] idx,
                                   input logic signed [23:0] qv, input logic signed [23:0] mv,
                                   input logic signed [7:0] code);
    dir_row_t r;
    r = '0;
    r.cmd = cmd;
    r.idx = idx;
    r.qv = qv;
    r.mv = mv;
    r.code = code;
    return r;
  endfunction

  function automatic dir_row_t req_known(input logic [1:0] cmd, input logic signed [7:0] code,
                                         input longint score, input logic skip,
                                         input logic [11:0] vn);
    dir_row_t r;
    r = req(cmd, '0, '0, '0, code);
    r.known = 1'b1;
    r.known_score.distance = score;
    r.known_score.skipped = skip;
    r.known_score.vector_number = vn;
    return r;
  endfunction

  function automatic dir_row_t reg_row(input logic sel, input logic [31:0] value);
    dir_row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.reg_sel = sel;
    r.reg_value = value;
    return r;
  endfunction

  function automatic logic [23:0] wide_value();
    case ($urandom_range(7))
      0: return Q_MAX;
      1: return Q_MIN;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] code_value();
    case ($urandom_range(9))
      0: return C_MAX;
      1: return C_MIN;
      2: return 8'd0;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_request(input logic [1:0] cmd, input logic [9:0] idx,
                              input logic signed [23:0] qv, input logic signed [23:0] mv,
                              input logic signed [7:0] code, input logic known,
                              input score_t known_score);
    score_t res;
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {6'b0, code, mv, qv, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    requests_sent++;
    if (predict_score(cmd, idx, qv, mv, code, res))
      pending_scores.push_back(known ? known_score : res);
  endtask

  // registers only change once the pipeline has drained
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_scores.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic sel, input logic [31:0] value);
    logic [31:0] readback;
    logic [10:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (sel == REG_METRIC_MODE) mode_reg = value[0];
    else dims_reg = value[10:0];
    settings_used++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    want = (sel == REG_METRIC_MODE) ? {10'b0, mode_reg} : dims_reg;
    if (((sel == REG_METRIC_MODE) ? {10'b0, readback[0]} : readback[10:0]) != want) begin
      $error("register %0d readback: expected %0d, got %0d", sel, want, readback);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    score_t want;
    m_tready <= ($urandom_range(99) >= stall_pct);
    if (m_tvalid && m_tready) begin
      if (pending_scores.size() == 0) begin
        $error("score with nothing pending: distance %0d", $signed(m_tdata[63:0]));
        errors++;
      end else begin
        want = pending_scores.pop_front();
        if (m_tdata[63:0] != want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, $signed(m_tdata[63:0]));
          errors++;
        end
        if (m_tuser != want.skipped) begin
          $error("skipped: expected %0d, got %0d", want.skipped, m_tuser);
          errors++;
        end
        if (m_tdata[75:64] != want.vector_number) begin
          $error("vector_number: expected %0d, got %0d", want.vector_number, m_tdata[75:64]);
          errors++;
        end
        if (want.skipped) skips_checked++;
        else scores_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int          sent;
    int          pick;
    logic [1:0]  cmd;
    logic [9:0]  idx;
    logic [23:0] qv;
    logic [23:0] mv;
    logic [7:0]  code;

    // extremes after reset; dims 0 and above the store size are folded
    directed_rows.push_back(req_known(CMD_SKIP, 8'sd0, 0, 1'b1, 12'd0));
    directed_rows.push_back(reg_row(REG_DIMS_IN_USE, 32'd1));
    directed_rows.push_back(req(CMD_LOAD, 10'd0, Q_MAX, Q_MAX, 8'sd0));
    directed_rows.push_back(req(CMD_CODE, 10'd0, '0, '0, C_MAX));
    directed_rows.push_back(req(CMD_CODE, 10'd0, '0, '0, C_MIN));
    directed_rows.push_back(req(CMD_LOAD, 10'd0, Q_MIN, Q_MIN, 8'sd0));
    directed_rows.push_back(req_known(CMD_CODE, C_MIN, N2_46, 1'b0, 12'd3));
    directed_rows.push_back(reg_row(REG_METRIC_MODE, 32'(MODE_L2)));
    directed_rows.push_back(req_known(CMD_CODE, 8'sd0, P2_46, 1'b0, 12'd4));
    directed_rows.push_back(req(CMD_CODE, 10'd0, '0, '0, C_MIN));
    directed_rows.push_back(reg_row(REG_DIMS_IN_USE, 32'd0));
    directed_rows.push_back(req_known(CMD_CODE, 8'sd1, 0, 1'b0, 12'd6));
    directed_rows.push_back(reg_row(REG_DIMS_IN_USE, 32'd2047));
    for (int d = 1; d < 7; d++)
      directed_rows.push_back(req(CMD_LOAD, d[9:0], Q_MIN, Q_MIN, 8'sd0));
    for (int n = 0; n < 3; n++)
      directed_rows.push_back(req(CMD_CODE, 10'd0, '0, '0, C_MIN));
    // load while a vector is open
    directed_rows.push_back(req(CMD_LOAD, 10'd7, Q_MIN, Q_MIN, 8'sd0));
    for (int n = 0; n < 4; n++)
      directed_rows.push_back(req(CMD_CODE, 10'd0, '0, '0, C_MIN));
    // count lowered below the open vector, eight maximal terms saturate
    directed_rows.push_back(reg_row(REG_DIMS_IN_USE, 32'd5));
    directed_rows.push_back(req_known(CMD_CODE, C_MIN, D_MAX, 1'b0, 12'd7));
    // mode switched halfway through a vector
    directed_rows.push_back(reg_row(REG_DIMS_IN_USE, 32'd2));
    directed_rows.push_back(req(CMD_CODE, 10'd0, '0, '0, 8'sd0));
    directed_rows.push_back(reg_row(REG_METRIC_MODE, 32'(MODE_DOT)));
    directed_rows.push_back(req(CMD_CODE, 10'd0, '0, '0, 8'sd1));
    // skip drops the partial sum
    directed_rows.push_back(req(CMD_CODE, 10'd0, '0, '0, 8'sd3));
    directed_rows.push_back(req_known(CMD_SKIP, 8'sd0, 0, 1'b1, 12'd9));
    directed_rows.push_back(req(CMD_UNUSED, 10'h3FF, Q_MAX, Q_MIN, C_MAX));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_reg) begin
        settle();
        write_register(directed_rows[i].reg_sel, directed_rows[i].reg_value);
      end else begin
        send_request(directed_rows[i].cmd, directed_rows[i].idx, directed_rows[i].qv,
                     directed_rows[i].mv, directed_rows[i].code, directed_rows[i].known,
                     directed_rows[i].known_score);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: dims_reg = 11'd1;
        1: dims_reg = 11'd0;
        2: dims_reg = 11'd2;
        3: dims_reg = 11'd3;
        4: dims_reg = 11'd2047;
        5: dims_reg = 11'd4;
        6: dims_reg = 11'd1024;
        7: dims_reg = 11'd5;
        default: dims_reg = 11'($urandom_range(16, 1));
      endcase
      write_register(REG_METRIC_MODE, (p < 8) ? 32'(p % 3 != 1) : $urandom_range(1));
      write_register(REG_DIMS_IN_USE, 32'(dims_reg));
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 77; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 77; end
        default: begin gap_pct = 14; stall_pct = 14; end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 3) cmd = CMD_UNUSED;
        else if (pick < 7) cmd = CMD_SKIP;
        else if (pick < 15) cmd = CMD_LOAD;
        else cmd = CMD_CODE;
        idx = 10'($urandom);
        qv = wide_value();
        mv = wide_value();
        code = code_value();
        // never read a dimension that has not been loaded
        if (cmd == CMD_CODE && !loaded[next_position()]) begin
          cmd = CMD_LOAD;
          idx = 10'(next_position());
        end
        send_request(cmd, idx, qv, mv, code, 1'b0, '0);
        if (cmd != CMD_UNUSED) sent++;
        if ($urandom_range(149) == 0) begin
          s_tvalid <= 1'b0;
          do @(posedge clk); while (pending_scores.size() != 0);
        end
      end
    end

    settle();
    if (pending_scores.size() != 0) begin
      $error("%0d scores never arrived", pending_scores.size());
      errors++;
    end
    $display("sent %0d requests across %0d register writes", requests_sent, settings_used);
    $display("checked %0d distances and %0d skipped vectors", scores_checked, skips_checked);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
